// ===== hw/rtl/emav_pkg.sv =====
// Package for the email address syntax checker.
// Holds character codes, counter limits, register indexes and shared types.
// No dependencies.
package emav_pkg;

   localparam logic [7:0] CHAR_AT  = 8'h40;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   localparam int unsigned CNT_W   = 7;
   localparam int unsigned LOCAL_W = 7;
   localparam int unsigned DOM_W   = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   localparam logic [LOCAL_W-1:0] LOCAL_MAX_RST  = 7'd64;
   localparam logic [DOM_W-1:0]   DOMAIN_MAX_RST = 6'd63;

   localparam int unsigned CSR_DATA_W = 7;

   typedef enum logic [0:0] {
      CSR_LOCAL_MAX  = 1'b0,
      CSR_DOMAIN_MAX = 1'b1
   } csr_index_type;

   // character class flags from the classifier
   typedef struct packed {
      logic is_at;
      logic is_dot;
      logic is_basic;
      logic is_extra;
   } char_class_type;

   // tracker status seen by the top level
   typedef struct packed {
      logic at_first;
      logic at_seen;
   } trk_status_type;

endpackage

// ===== hw/rtl/emav_if.sv =====
// Channel interfaces for the email address syntax checker.
// Request carries one character per transaction, response one verdict.
// No dependencies.
interface emav_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface emav_rsp_if;
   logic valid;
   logic ready;
   logic address_ok;

   modport source (output valid, output address_ok, input ready);
   modport sink   (input valid, input address_ok, output ready);
endinterface

// ===== hw/rtl/email_address_validator_core.sv =====
// Email address syntax checker, top level.
// The address enters on req_ch one character per transaction, is_final set on
// the last one. Non-final characters give no response; the final character
// gives exactly one transaction on rsp_ch with address_ok set if the address
// passes all rules. The tracker then starts over for the next address.
// Part length limits are written through csr_wr_en/csr_index/csr_wdata while
// the block is idle; they keep their values across addresses.
// A final character accepted on req_ch is held in the input register; the single
// classify-and-update step then writes its verdict to the result register, which
// drives rsp_ch. Throughput: one character per cycle, set by that single step, but:
// when rsp_ch stalls with a verdict pending, non-final characters still flow;
// a following final character waits in the input register and req_ch.ready
// drops until the pending verdict is taken.
// Reset (synchronous, active high) empties both registers, clears the tracker
// and restores the limits to 64 and 63.
module email_address_validator_core
   import emav_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   emav_req_if.sink              req_ch,
   emav_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic               s1_valid_ff;
   logic [7:0]         s1_char_ff;
   logic               s1_final_ff;
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff;
   logic [LOCAL_W-1:0] local_max_ff;
   logic [DOM_W-1:0]   domain_max_ff;
   logic               out_free;
   logic               step;
   logic               verdict;
   char_class_type     char_class;
   trk_status_type     trk_status;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step         = s1_valid_ff && (!s1_final_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_max_ff  <= LOCAL_MAX_RST;
         domain_max_ff <= DOMAIN_MAX_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LOCAL_MAX:  local_max_ff  <= csr_wdata;
            CSR_DOMAIN_MAX: domain_max_ff <= csr_wdata[DOM_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         s1_char_ff  <= req_ch.char_code;
         s1_final_ff <= req_ch.is_final;
      end
   end

   emav_classify u_classify (
      .char_code  (s1_char_ff),
      .char_class (char_class)
   );

   emav_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .char_class (char_class),
      .is_final   (s1_final_ff),
      .local_max  (local_max_ff),
      .domain_max (domain_max_ff),
      .address_ok (verdict),
      .status     (trk_status)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (step && s1_final_ff) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step && s1_final_ff) begin
         out_ok_ff <= verdict;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.address_ok = out_ok_ff;

`ifndef NO_ASSERTIONS
   a_final_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (step && s1_final_ff) |=> out_valid_ff)
      else $error("final character did not produce a response");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff)) |-> $past(step && s1_final_ff))
      else $error("response without a final character");

   a_tracker_restart: assert property (@(posedge clock) disable iff (reset)
      (step && s1_final_ff) |=> (trk_status.at_first && !trk_status.at_seen))
      else $error("tracker not cleared after final character");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_final_ff && out_valid_ff && !rsp_ch.ready))
      else $error("request stalled without a pending verdict");
`endif

endmodule

// ===== hw/rtl/emav_classify.sv =====
// Character classifier: sorts one 8-bit code into the allowed sets.
// Depends on emav_pkg.
module emav_classify
   import emav_pkg::*;
(
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_at    = (char_code == CHAR_AT);
      char_class.is_dot   = (char_code == CHAR_DOT);
      char_class.is_basic = (char_code inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                               8'h2D, CHAR_DOT});
      // !#$%&'*+-/=?^_`{|}~
      char_class.is_extra = (char_code inside {8'h21, [8'h23:8'h27], 8'h2A, 8'h2B, 8'h2D,
                                               8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60,
                                               [8'h7B:8'h7E]});
   end

endmodule

// ===== hw/rtl/emav_tracker.sv =====
// Address state tracker: part counters, '@' and dot history, sticky error.
// Produces the verdict on the final character. Depends on emav_pkg.
module emav_tracker
   import emav_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  char_class_type     char_class,
   input  logic               is_final,
   input  logic [LOCAL_W-1:0] local_max,
   input  logic [DOM_W-1:0]   domain_max,
   output logic               address_ok,
   output trk_status_type     status
);

   logic [CNT_W-1:0] local_cnt_ff, local_cnt_in;
   logic [CNT_W-1:0] dom_cnt_ff, dom_cnt_in;
   logic             at_seen_ff, at_seen_in;
   logic             prev_dot_ff, prev_dot_in;
   logic             first_ff, first_in;
   logic             err_ff, err_in;
   logic             bad;

   always_comb begin
      bad          = err_ff;
      local_cnt_in = local_cnt_ff;
      dom_cnt_in   = dom_cnt_ff;
      at_seen_in   = at_seen_ff;
      prev_dot_in  = prev_dot_ff;
      first_in     = 1'b0;

      if (char_class.is_at) begin
         if (at_seen_ff || first_ff) bad = 1'b1;
         at_seen_in  = 1'b1;
         prev_dot_in = 1'b0;
      end else begin
         if (char_class.is_dot) begin
            if (first_ff || prev_dot_ff) bad = 1'b1;
            prev_dot_in = 1'b1;
         end else begin
            if (!char_class.is_basic && !(!at_seen_ff && char_class.is_extra)) bad = 1'b1;
            prev_dot_in = 1'b0;
         end
         if (at_seen_ff) begin
            if (dom_cnt_ff != CNT_MAX) dom_cnt_in = dom_cnt_ff + 1'b1;
         end else begin
            if (local_cnt_ff != CNT_MAX) local_cnt_in = local_cnt_ff + 1'b1;
         end
      end

      // end-of-address checks use the counts including this character
      if (is_final) begin
         if (char_class.is_at || char_class.is_dot || !at_seen_in) bad = 1'b1;
         if (local_cnt_in == '0 || local_cnt_in > local_max) bad = 1'b1;
         if (dom_cnt_in == '0 || dom_cnt_in > {1'b0, domain_max}) bad = 1'b1;
      end
      err_in     = bad;
      address_ok = !bad;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && is_final)) begin
         local_cnt_ff <= '0;
         dom_cnt_ff   <= '0;
         at_seen_ff   <= 1'b0;
         prev_dot_ff  <= 1'b0;
         first_ff     <= 1'b1;
         err_ff       <= 1'b0;
      end else if (step) begin
         local_cnt_ff <= local_cnt_in;
         dom_cnt_ff   <= dom_cnt_in;
         at_seen_ff   <= at_seen_in;
         prev_dot_ff  <= prev_dot_in;
         first_ff     <= first_in;
         err_ff       <= err_in;
      end
   end

   assign status.at_first = first_ff;
   assign status.at_seen  = at_seen_ff;

endmodule

// ===== dv/email_address_validator_core_test.sv =====
// Self-checking testbench for email_address_validator_core.
// Streams addresses a character per transaction and checks each verdict against
// a local tracker. Depends on emav_pkg, emav_if.sv and the core RTL.
module email_address_validator_core_test;
   import emav_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int MAX_SHOWN      = 10;

   // extra symbols, all accepted in the local part: ! # $ % & ' * + - / = ? ^ _ ` { | } ~
   localparam logic [7:0] EXTRA_SYMS [19] = '{
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
      8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
   };

   typedef struct packed {
      logic [7:0] code;
      bit         fin;
      bit         typed;
      bit         ok;
   } char_row_type;

   // typed verdicts only where the outcome is obvious; the rest go to the tracker
   localparam char_row_type DIRECTED_ROWS [25] = '{
      '{"a", 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{"b", 1, 1, 1},
      '{CHAR_AT, 1, 1, 0},
      '{8'h00, 1, 1, 0},
      '{"~", 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{"Z", 1, 1, 1},
      '{"0", 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{"~", 1, 1, 0},
      '{8'h80, 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{"9", 1, 1, 0},
      '{"a", 0, 0, 0}, '{CHAR_DOT, 0, 0, 0}, '{CHAR_AT, 0, 0, 0},
      '{CHAR_DOT, 0, 0, 0}, '{"b", 1, 0, 0},
      '{CHAR_DOT, 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{"a", 1, 1, 0},
      '{"a", 0, 0, 0}, '{CHAR_AT, 0, 0, 0}, '{CHAR_DOT, 1, 1, 0}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [0:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   emav_req_if req_ch ();
   emav_rsp_if rsp_ch ();

   email_address_validator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tracker state, mirrors the block
   logic [LOCAL_W-1:0] lim_local  = LOCAL_MAX_RST;
   logic [DOM_W-1:0]   lim_domain = DOMAIN_MAX_RST;
   logic [CNT_W-1:0]   trk_local_cnt  = '0;
   logic [CNT_W-1:0]   trk_domain_cnt = '0;
   bit trk_at_seen  = 0;
   bit trk_prev_dot = 0;
   bit trk_first    = 1;
   bit trk_err      = 0;

   bit verdict_q[$];
   int fail_count  = 0;
   int idle_cycles = 0;
   bit req_gaps_on = 1;
   bit rsp_gaps_on = 1;
   bit hold_req    = 0;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void report_fail(string msg);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("%s", msg);
   endfunction

   function automatic bit is_basic_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "-" || c == CHAR_DOT;
   endfunction

   function automatic bit is_extra_char(logic [7:0] c);
      foreach (EXTRA_SYMS[i])
         if (EXTRA_SYMS[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // advance the address tracker by one character; on the final one, give the verdict
   function automatic void track_char(input logic [7:0] c, input bit fin,
                                      output bit due, output bit ok);
      bit bad;
      bad = trk_err;
      due = fin;
      ok  = 1'b0;
      if (c == CHAR_AT) begin
         if (trk_at_seen || trk_first) bad = 1'b1;
         trk_at_seen  = 1'b1;
         trk_prev_dot = 1'b0;
      end else begin
         if (c == CHAR_DOT) begin
            if (trk_first || trk_prev_dot) bad = 1'b1;
            trk_prev_dot = 1'b1;
         end else begin
            if (!is_basic_char(c) && !(!trk_at_seen && is_extra_char(c))) bad = 1'b1;
            trk_prev_dot = 1'b0;
         end
         if (trk_at_seen) trk_domain_cnt = sat_inc(trk_domain_cnt);
         else trk_local_cnt = sat_inc(trk_local_cnt);
      end
      trk_first = 1'b0;
      if (!fin) begin
         trk_err = bad;
         return;
      end
      if (c == CHAR_AT || c == CHAR_DOT || !trk_at_seen) bad = 1'b1;
      if (trk_local_cnt == 0 || trk_local_cnt > lim_local) bad = 1'b1;
      if (trk_domain_cnt == 0 || trk_domain_cnt > lim_domain) bad = 1'b1;
      ok = !bad;
      trk_local_cnt  = '0;
      trk_domain_cnt = '0;
      trk_at_seen    = 1'b0;
      trk_prev_dot   = 1'b0;
      trk_first      = 1'b1;
      trk_err        = 1'b0;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [7:0] basic_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return "-";
   endfunction

   function automatic logic [7:0] noise_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return CHAR_AT;
      if (r < 40) return CHAR_DOT;
      if (r < 70) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic int pick_len(int lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 88) return (lim < 2) ? $urandom_range(1, 2) : lim + $urandom_range(0, 2) - 1;
      if (r < 97) return $urandom_range(1, lim + 2);
      return $urandom_range(118, 140);   // long parts; from 127 characters on, enough to saturate the counter
   endfunction

   task automatic send_char(logic [7:0] c, bit fin, bit typed, bit typed_ok);
      int gap;
      bit due;
      bit ok;
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.is_final  <= fin;
      do @(posedge clock); while (!req_ch.ready);
      track_char(c, fin, due, ok);
      if (due) verdict_q.push_back(typed ? typed_ok : ok);
   endtask

   task automatic build_part(ref logic [7:0] chars[$], input int n, input bit is_local);
      bit prev_dot;
      bit dot_ok;
      prev_dot = 1'b0;
      for (int i = 0; i < n; i++) begin
         dot_ok = !prev_dot && (is_local ? i > 0 : i < n - 1);
         if (dot_ok && $urandom_range(0, 99) < 10) begin
            chars.push_back(CHAR_DOT);
            prev_dot = 1'b1;
         end else begin
            if (is_local && $urandom_range(0, 99) < 35)
               chars.push_back(EXTRA_SYMS[$urandom_range(0, 18)]);
            else
               chars.push_back(basic_char());
            prev_dot = 1'b0;
         end
      end
   endtask

   // addresses with random content and part lengths, some over the limits, some with
   // one corrupted character, and short bursts of noise
   task automatic send_random_address(output int n_sent);
      logic [7:0] chars[$];
      int kind;
      int pos;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) chars.push_back(noise_char());
      end else begin
         build_part(chars, pick_len(lim_local), 1'b1);
         chars.push_back(CHAR_AT);
         build_part(chars, pick_len(lim_domain), 1'b0);
         if (kind >= 78) begin
            pos = $urandom_range(0, chars.size() - 1);
            chars[pos] = noise_char();
         end
      end
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, 1'b0);
      n_sent = chars.size();
   endtask

   task automatic run_phase(int goal);
      int sent;
      int k;
      sent = 0;
      while (sent < goal) begin
         send_random_address(k);
         sent += k;
      end
   endtask

   // block must be idle before the limits change
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limits(logic [CSR_DATA_W-1:0] local_val,
                               logic [CSR_DATA_W-1:0] domain_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LOCAL_MAX;
      csr_wdata <= local_val;
      @(posedge clock);
      lim_local = local_val;
      csr_index <= CSR_DOMAIN_MAX;
      csr_wdata <= domain_val;
      @(posedge clock);
      lim_domain = domain_val[DOM_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // verdict checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_q.size() == 0) begin
            report_fail($sformatf("ERROR: verdict %0b at %0t with none pending",
                                  rsp_ch.address_ok, $time));
         end else if (verdict_q[0] != rsp_ch.address_ok) begin
            report_fail($sformatf("ERROR: verdict mismatch at %0t: expected %0b, got %0b",
                                  $time, verdict_q[0], rsp_ch.address_ok));
            void'(verdict_q.pop_front());
         end else begin
            void'(verdict_q.pop_front());
         end
      end
   end

   // watchdog on transactions in either direction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            gap = pick_gap(rsp_gaps_on);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] dom_val;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.is_final  = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_LOCAL_MAX;
      csr_wdata        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i])
         send_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].fin,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].ok);
      settle();

      run_phase(100);

      // response side held off while characters keep coming
      hold_req    = 1'b1;
      req_gaps_on = 1'b0;
      // short addresses outlast the pickup of the hold, so a verdict backs up and req_ch stalls
      repeat (15) begin
         send_char("a", 1'b0, 1'b0, 1'b0);
         send_char(CHAR_AT, 1'b0, 1'b0, 1'b0);
         send_char("b", 1'b1, 1'b0, 1'b0);
      end
      run_phase(40);
      req_gaps_on = 1'b1;
      settle();

      write_limits(7'd1, 7'd1);
      run_phase(60);
      settle();

      // zero limits reject everything
      write_limits(7'd0, 7'd0);
      run_phase(30);
      settle();

      // widest limits, bit 6 of the domain write is dropped; no idling here
      write_limits(7'd127, 7'h7F);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_phase(80);
      settle();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;

      dom_val = 7'($urandom_range(0, 127));
      write_limits(7'($urandom_range(1, 127)), dom_val);
      run_phase(80);
      settle();

      write_limits(LOCAL_MAX_RST, 7'(DOMAIN_MAX_RST));
      run_phase(60);
      settle();
      repeat (5) @(posedge clock);

      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
